// ===== src/ufb_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the UART frame builder.
// No dependencies.
package ufb_pkg;

    localparam int unsigned FIFO_DEPTH = 4;

    localparam logic [7:0]  FRAME_MAGIC   = 8'hAA;
    localparam logic [15:0] CRC_POLY      = 16'h8005;
    localparam logic [15:0] LEN_OFFSET    = 16'd11;
    localparam logic [15:0] SIZE_OFFSET   = 16'd10;

    localparam logic [15:0] RST_PAYLOAD_LEN   = 16'd0;
    localparam logic [7:0]  RST_COMMAND_CODE  = 8'h85;
    localparam logic [15:0] RST_FRAME_NUMBER  = 16'd1;
    localparam logic [31:0] RST_START_ADDRESS = 32'd0;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAYLOAD_LEN   = 2'd0,
        CFG_COMMAND_CODE  = 2'd1,
        CFG_FRAME_NUMBER  = 2'd2,
        CFG_START_ADDRESS = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] payload_len;
        logic [7:0]  command_code;
        logic [15:0] frame_number;
        logic [31:0] start_address;
    } t_cfg;

    // One queued job for the back end: a header, or one payload byte;
    // tail asks for CRC and checksum after it.
    typedef struct packed {
        logic       is_start;
        logic       tail;
        logic [7:0] data;
    } t_cmd;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== src/ufb_if.sv =====
// Valid/ready channel interfaces for the frame builder's input and output.
// Depends on nothing.
interface ufb_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] data_byte;

    modport source (output valid, output req_type, output data_byte, input ready);
    modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

interface ufb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;

    modport source (output valid, output frame_byte, output frame_end, input ready);
    modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

// ===== src/ufb_fifo.sv =====
// Short command queue between front and back end.
// Depends on ufb_pkg.
module ufb_fifo #(
    parameter int unsigned DEPTH = ufb_pkg::FIFO_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ufb_pkg::t_cmd i_push_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output ufb_pkg::t_cmd o_head,
    output logic          o_empty
);
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    ufb_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

// ===== src/ufb_front.sv =====
// Front end: takes input transactions, tracks the open frame and queues jobs.
// Depends on ufb_pkg and ufb_in_if.
module ufb_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ufb_in_if.sink        i_in,
    input  ufb_pkg::t_cfg i_cfg,
    input  logic          i_q_full,
    output logic          o_push,
    output ufb_pkg::t_cmd o_push_cmd
);
    logic        r_in_frame, n_in_frame;
    logic [15:0] r_bytes_left, n_bytes_left;
    logic        accept;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;

    always_comb begin
        n_in_frame      = r_in_frame;
        n_bytes_left    = r_bytes_left;
        o_push          = 1'b0;
        o_push_cmd.is_start = !i_in.req_type;
        o_push_cmd.data     = i_in.data_byte;
        o_push_cmd.tail     = 1'b0;
        if (accept) begin
            if (!i_in.req_type) begin
                o_push          = 1'b1;
                o_push_cmd.tail = (i_cfg.payload_len == '0);
                n_in_frame      = (i_cfg.payload_len != '0);
                n_bytes_left    = i_cfg.payload_len;
            end else if (r_in_frame && r_bytes_left != '0) begin
                o_push          = 1'b1;
                o_push_cmd.tail = (r_bytes_left == 16'd1);
                n_bytes_left    = r_bytes_left - 16'd1;
                n_in_frame      = (r_bytes_left != 16'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame   <= 1'b0;
            r_bytes_left <= '0;
        end else begin
            r_in_frame   <= n_in_frame;
            r_bytes_left <= n_bytes_left;
        end
    end

endmodule

// ===== src/ufb_back.sv =====
// Back end: walks each queued job byte by byte, runs CRC and checksum, output register.
// Depends on ufb_pkg and ufb_out_if.
module ufb_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ufb_pkg::t_cfg i_cfg,
    input  ufb_pkg::t_cmd i_head,
    input  logic          i_empty,
    output logic          o_pop,
    ufb_out_if.source     o_out
);
    localparam logic [3:0] STEP_MAGIC  = 4'd0;
    localparam logic [3:0] STEP_LEN_HI = 4'd1;
    localparam logic [3:0] STEP_LEN_LO = 4'd2;
    localparam logic [3:0] STEP_CMD    = 4'd3;
    localparam logic [3:0] STEP_FN_HI  = 4'd4;
    localparam logic [3:0] STEP_FN_LO  = 4'd5;
    localparam logic [3:0] STEP_ADDR3  = 4'd6;
    localparam logic [3:0] STEP_ADDR2  = 4'd7;
    localparam logic [3:0] STEP_ADDR1  = 4'd8;
    localparam logic [3:0] STEP_ADDR0  = 4'd9;
    localparam logic [3:0] STEP_SZ_HI  = 4'd10;
    localparam logic [3:0] STEP_SZ_LO  = 4'd11;
    localparam logic [3:0] STEP_DATA   = 4'd12;
    localparam logic [3:0] STEP_CRC_HI = 4'd13;
    localparam logic [3:0] STEP_CRC_LO = 4'd14;
    localparam logic [3:0] STEP_SUM    = 4'd15;

    logic        r_mid, n_mid;
    logic [3:0]  r_step, n_step;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_sum, n_sum;
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_byte, n_out_byte;
    logic        r_out_end, n_out_end;

    logic        emit;
    logic [3:0]  step;
    logic [7:0]  cur_byte;
    logic [15:0] len_field;
    logic [15:0] size_field;

    assign len_field  = i_cfg.payload_len + ufb_pkg::LEN_OFFSET;
    assign size_field = i_cfg.payload_len + ufb_pkg::SIZE_OFFSET;
    assign step       = r_mid ? r_step : (i_head.is_start ? STEP_MAGIC : STEP_DATA);
    assign emit       = !i_empty && (!r_out_valid || o_out.ready);

    always_comb begin
        unique case (step)
            STEP_MAGIC:  cur_byte = ufb_pkg::FRAME_MAGIC;
            STEP_LEN_HI: cur_byte = len_field[15:8];
            STEP_LEN_LO: cur_byte = len_field[7:0];
            STEP_CMD:    cur_byte = i_cfg.command_code;
            STEP_FN_HI:  cur_byte = i_cfg.frame_number[15:8];
            STEP_FN_LO:  cur_byte = i_cfg.frame_number[7:0];
            STEP_ADDR3:  cur_byte = i_cfg.start_address[31:24];
            STEP_ADDR2:  cur_byte = i_cfg.start_address[23:16];
            STEP_ADDR1:  cur_byte = i_cfg.start_address[15:8];
            STEP_ADDR0:  cur_byte = i_cfg.start_address[7:0];
            STEP_SZ_HI:  cur_byte = size_field[15:8];
            STEP_SZ_LO:  cur_byte = size_field[7:0];
            STEP_DATA:   cur_byte = i_head.data;
            STEP_CRC_HI: cur_byte = r_crc[15:8];
            STEP_CRC_LO: cur_byte = r_crc[7:0];
            STEP_SUM:    cur_byte = r_sum;
            default:     cur_byte = r_sum;
        endcase
    end

    always_comb begin
        n_mid       = r_mid;
        n_step      = r_step;
        n_crc       = r_crc;
        n_sum       = r_sum;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_byte  = r_out_byte;
        n_out_end   = r_out_end;
        o_pop       = 1'b0;
        if (emit) begin
            n_out_valid = 1'b1;
            n_out_byte  = cur_byte;
            n_out_end   = (step == STEP_SUM);

            if (step == STEP_MAGIC) begin
                n_crc = '0;
                n_sum = '0;
            end else begin
                if (step >= STEP_ADDR3 && step <= STEP_DATA) begin
                    n_crc = ufb_pkg::crc16_byte(r_crc, cur_byte);
                end
                if (step >= STEP_CMD && step <= STEP_CRC_LO) begin
                    n_sum = r_sum + cur_byte;
                end
            end

            // last byte of the job: header without tail, plain data, or checksum
            if (((step == STEP_SZ_LO || step == STEP_DATA) && !i_head.tail)
                    || step == STEP_SUM) begin
                o_pop = 1'b1;
                n_mid = 1'b0;
            end else if (step == STEP_SZ_LO) begin
                n_mid  = 1'b1;
                n_step = STEP_CRC_HI;
            end else begin
                n_mid  = 1'b1;
                n_step = step + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid       <= 1'b0;
            r_step      <= STEP_MAGIC;
            r_crc       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mid       <= n_mid;
            r_step      <= n_step;
            r_crc       <= n_crc;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_out_end  <= n_out_end;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.frame_byte = r_out_byte;
    assign o_out.frame_end  = r_out_end;

    a_end_on_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && step == STEP_SUM |=> r_out_valid && r_out_end)
        else $error("frame end missing after checksum byte");

    a_no_early_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && step != STEP_SUM |=> !r_out_end)
        else $error("frame end raised before checksum byte");

    a_pop_needs_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> emit)
        else $error("job retired without a byte sent");

    a_mid_has_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mid |-> !i_empty)
        else $error("job in progress but queue empty");

endmodule

// ===== src/uart_frame_builder_crc16_checksum_top.sv =====
// Top level of the UART frame builder: configuration registers, front end, queue, back end.
// Depends on ufb_pkg, ufb_if, ufb_front, ufb_fifo and ufb_back.
//
// Builds length-prefixed serial frames, one byte per output transaction. A start
// transaction yields the 12-byte header (15 bytes with the CRC pair and checksum when
// the payload length is zero); each payload transaction in an open frame yields its
// byte, and the last one also yields CRC high, CRC low and the checksum byte flagged
// with frame_end. Input is taken every cycle while the job queue has room; the back
// end sends one byte per cycle unless the receiver stalls it. Its CRC-16 covers the
// address, size and payload bytes, its sum every byte from the command code to the CRC
// pair. Configuration writes take effect at the next start and must be made while idle.
module uart_frame_builder_crc16_checksum_top #(
    parameter int unsigned FIFO_DEPTH = ufb_pkg::FIFO_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ufb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ufb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ufb_in_if.sink                         i_in,
    ufb_out_if.source                      o_out
);
    ufb_pkg::t_cfg r_cfg;
    ufb_pkg::t_cmd push_cmd;
    ufb_pkg::t_cmd head;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.payload_len   <= ufb_pkg::RST_PAYLOAD_LEN;
            r_cfg.command_code  <= ufb_pkg::RST_COMMAND_CODE;
            r_cfg.frame_number  <= ufb_pkg::RST_FRAME_NUMBER;
            r_cfg.start_address <= ufb_pkg::RST_START_ADDRESS;
        end else if (i_cfg_we) begin
            unique case (ufb_pkg::t_cfg_idx'(i_cfg_idx))
                ufb_pkg::CFG_PAYLOAD_LEN:   r_cfg.payload_len   <= i_cfg_data[15:0];
                ufb_pkg::CFG_COMMAND_CODE:  r_cfg.command_code  <= i_cfg_data[7:0];
                ufb_pkg::CFG_FRAME_NUMBER:  r_cfg.frame_number  <= i_cfg_data[15:0];
                ufb_pkg::CFG_START_ADDRESS: r_cfg.start_address <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    ufb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg      (r_cfg),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_push_cmd (push_cmd)
    );

    ufb_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .o_full     (q_full),
        .i_pop      (pop),
        .o_head     (head),
        .o_empty    (q_empty)
    );

    ufb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_head  (head),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

// ===== bench/tb_uart_frame_builder_crc16_checksum_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for uart_frame_builder_crc16_checksum_top: predicts every frame byte
// and compares it with each output transaction. Depends on ufb_pkg, ufb_if and the RTL.
module tb_uart_frame_builder_crc16_checksum_top;

    localparam logic        REQ_START     = 1'b0;
    localparam logic        REQ_DATA      = 1'b1;
    localparam logic [7:0]  HDR_SYNC      = 8'hAA;
    localparam logic [15:0] CRC16_POLY    = 16'h8005;
    localparam int          SETTLE_CYCLES = 20;
    localparam int          LIMIT_CYCLES  = 200000;

    typedef struct packed {
        logic [7:0] fbyte;
        logic       fend;
    } t_frame_byte;

    bit                             i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [ufb_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [ufb_pkg::CFG_DATA_W-1:0] i_cfg_data;

    ufb_in_if  in_ch();
    ufb_out_if out_ch();

    uart_frame_builder_crc16_checksum_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // shadow of the block's registers and frame state
    ufb_pkg::t_cfg shadow_cfg;
    bit            pr_in_frame;
    logic [15:0]   pr_left;
    logic [15:0]   pr_crc;
    logic [7:0]    pr_sum;
    t_frame_byte   frame_bytes_due[$];

    int mismatches   = 0;
    bit idle_on      = 1'b1;
    int rx_hold_req  = 0;
    int cycle_count  = 0;

    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[15] ^ b[i];
            r  = {r[14:0], 1'b0};
            if (fb) begin
                r = r ^ CRC16_POLY;
            end
        end
        return r;
    endfunction

    function automatic void push_byte(input logic [7:0] v, input logic fend);
        t_frame_byte fb;
        fb.fbyte = v;
        fb.fend  = fend;
        frame_bytes_due.push_back(fb);
    endfunction

    function automatic void push_summed(input logic [7:0] v);
        pr_sum = pr_sum + v;
        push_byte(v, 1'b0);
    endfunction

    function automatic void push_covered(input logic [7:0] v);
        pr_crc = crc16_update(pr_crc, v);
        push_summed(v);
    endfunction

    function automatic void push_trailer();
        push_summed(pr_crc[15:8]);
        push_summed(pr_crc[7:0]);
        push_byte(pr_sum, 1'b1);
        pr_in_frame = 1'b0;
        pr_left     = '0;
    endfunction

    function automatic void predict_frame_bytes(input logic req, input logic [7:0] data);
        logic [15:0] len_f;
        logic [15:0] size_f;
        if (req == REQ_START) begin
            len_f  = shadow_cfg.payload_len + 16'd11;
            size_f = shadow_cfg.payload_len + 16'd10;
            pr_crc = '0;
            pr_sum = '0;
            push_byte(HDR_SYNC, 1'b0);
            push_byte(len_f[15:8], 1'b0);
            push_byte(len_f[7:0], 1'b0);
            push_summed(shadow_cfg.command_code);
            push_summed(shadow_cfg.frame_number[15:8]);
            push_summed(shadow_cfg.frame_number[7:0]);
            push_covered(shadow_cfg.start_address[31:24]);
            push_covered(shadow_cfg.start_address[23:16]);
            push_covered(shadow_cfg.start_address[15:8]);
            push_covered(shadow_cfg.start_address[7:0]);
            push_covered(size_f[15:8]);
            push_covered(size_f[7:0]);
            pr_in_frame = 1'b1;
            pr_left     = shadow_cfg.payload_len;
            if (pr_left == 16'd0) begin
                push_trailer();
            end
        end else if (pr_in_frame && pr_left != 16'd0) begin
            push_covered(data);
            pr_left = pr_left - 16'd1;
            if (pr_left == 16'd0) begin
                push_trailer();
            end
        end
    endfunction

    // output checker
    always @(posedge i_clk) begin
        t_frame_byte want;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (frame_bytes_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected transaction: byte %02h end %0b",
                             out_ch.frame_byte, out_ch.frame_end);
                end
            end else begin
                want = frame_bytes_due.pop_front();
                if (out_ch.frame_byte !== want.fbyte || out_ch.frame_end !== want.fend) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected byte %02h end %0b, got byte %02h end %0b",
                                 want.fbyte, want.fend, out_ch.frame_byte, out_ch.frame_end);
                    end
                end
            end
        end
    end

    // receiver: random stall bursts plus an occasional long hold-off
    initial begin
        int hold_left;
        int burst_left;
        hold_left    = 0;
        burst_left   = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req != 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (burst_left > 0) begin
                burst_left--;
                out_ch.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                burst_left = $urandom_range(0, 3);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("uart_frame_builder_crc16_checksum_top regression: fail");
        $finish;
    end

    task automatic send_item(input logic req, input logic [7:0] data);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.req_type  <= req;
        in_ch.data_byte <= data;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        predict_frame_bytes(req, data);
    endtask

    task automatic wait_all_out();
        in_ch.valid <= 1'b0;
        while (frame_bytes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input ufb_pkg::t_cfg_idx idx, input logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        unique case (idx)
            ufb_pkg::CFG_PAYLOAD_LEN:   shadow_cfg.payload_len   = val[15:0];
            ufb_pkg::CFG_COMMAND_CODE:  shadow_cfg.command_code  = val[7:0];
            ufb_pkg::CFG_FRAME_NUMBER:  shadow_cfg.frame_number  = val[15:0];
            ufb_pkg::CFG_START_ADDRESS: shadow_cfg.start_address = val;
            default: ;
        endcase
    endtask

    task automatic load_regs(input logic [15:0] len, input logic [7:0] cmd,
                             input logic [15:0] fnum, input logic [31:0] addr);
        wait_all_out();
        cfg_write(ufb_pkg::CFG_PAYLOAD_LEN, {16'd0, len});
        cfg_write(ufb_pkg::CFG_COMMAND_CODE, {24'd0, cmd});
        cfg_write(ufb_pkg::CFG_FRAME_NUMBER, {16'd0, fnum});
        cfg_write(ufb_pkg::CFG_START_ADDRESS, addr);
        i_cfg_we <= 1'b0;
    endtask

    // stray data before any frame, then an empty frame with the reset settings
    task automatic test_reset_values();
        send_item(REQ_DATA, 8'h5A);
        send_item(REQ_START, 8'h00);
        wait_all_out();
    endtask

    task automatic test_field_extremes();
        load_regs(16'd0, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(REQ_START, 8'hFF);
        load_regs(16'd0, 8'h00, 16'h0000, 32'h0000_0000);
        send_item(REQ_START, 8'h00);
    endtask

    task automatic test_short_payload();
        load_regs(16'd3, 8'h85, 16'h1234, 32'h8000_0001);
        send_item(REQ_START, 8'h00);
        send_item(REQ_DATA, 8'h00);
        send_item(REQ_DATA, 8'hFF);
        send_item(REQ_DATA, 8'hA5);
        send_item(REQ_DATA, 8'h3C);
    endtask

    // restart inside an open frame, wrapped length fields, largest length
    task automatic test_restart_and_wrap();
        load_regs(16'hFFFF, 8'h42, 16'h0002, 32'h0000_FFFF);
        send_item(REQ_START, 8'h11);
        send_item(REQ_DATA, 8'h01);
        send_item(REQ_START, 8'h22);
        send_item(REQ_DATA, 8'h80);
        load_regs(16'd65520, 8'h7E, 16'h8000, 32'h1234_5678);
        send_item(REQ_START, 8'h33);
        send_item(REQ_DATA, 8'h7F);
        load_regs(16'd1, 8'h01, 16'h00FF, 32'hDEAD_BEEF);
        send_item(REQ_START, 8'h44);
        send_item(REQ_DATA, 8'hFE);
    endtask

    // long receiver hold-off fills the job queue; then the sender waits for the drain
    task automatic test_output_backpressure();
        load_regs(16'd20, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                  $urandom());
        rx_hold_req = 150;
        send_item(REQ_START, 8'($urandom_range(0, 255)));
        repeat (20) send_item(REQ_DATA, 8'($urandom_range(0, 255)));
        wait_all_out();
    endtask

    task automatic test_random_frames(input int n_items);
        int sent;
        int nbytes;
        int plen;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 3) == 0) begin
                plen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                   : $urandom_range(0, 8);
                load_regs(16'(plen), 8'($urandom_range(0, 255)),
                          16'($urandom_range(0, 65535)), $urandom());
            end else if ($urandom_range(0, 9) == 0) begin
                wait_all_out();
            end
            send_item(REQ_START, 8'($urandom_range(0, 255)));
            sent++;
            nbytes = int'(shadow_cfg.payload_len);
            // truncated frame, abandoned by the next start
            if ($urandom_range(0, 7) == 0) begin
                nbytes = $urandom_range(0, nbytes);
            end
            repeat (nbytes) begin
                send_item(REQ_DATA, 8'($urandom_range(0, 255)));
                sent++;
            end
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, 2)) send_item(REQ_DATA, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = ufb_pkg::CFG_PAYLOAD_LEN;
        i_cfg_data      = '0;
        in_ch.valid     = 1'b0;
        in_ch.req_type  = REQ_START;
        in_ch.data_byte = 8'h00;
        shadow_cfg.payload_len   = 16'd0;
        shadow_cfg.command_code  = 8'h85;
        shadow_cfg.frame_number  = 16'd1;
        shadow_cfg.start_address = 32'd0;
        pr_in_frame = 1'b0;
        pr_left     = '0;
        pr_crc      = '0;
        pr_sum      = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_field_extremes();
        test_short_payload();
        test_restart_and_wrap();
        test_output_backpressure();
        test_random_frames(100);
        idle_on = 1'b0;
        test_random_frames(35);
        wait_all_out();

        if (mismatches == 0 && frame_bytes_due.size() == 0) begin
            $display("uart_frame_builder_crc16_checksum_top regression: pass");
        end else begin
            $display("uart_frame_builder_crc16_checksum_top regression: fail");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
src/ufb_pkg.sv
src/ufb_if.sv
src/ufb_fifo.sv
src/ufb_front.sv
src/ufb_back.sv
src/uart_frame_builder_crc16_checksum_top.sv
bench/tb_uart_frame_builder_crc16_checksum_top.sv
